@@ hdl/qsu_pkg.sv @@
// Shared types and constants for the quoted string unescaper.
// Holds the transaction structs, the parser phase and result kind codes, and character codes.
// Depends on nothing; every other file imports it.
package qsu_pkg;

    // result kinds
    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_DONE = 2'd1,
        KIND_ERR  = 2'd2
    } qsu_kind_t;

    // parser phases
    typedef enum logic [2:0] {
        PH_SKIP  = 3'd0,
        PH_STR   = 3'd1,
        PH_ESC   = 3'd2,
        PH_OCT   = 3'd3,
        PH_HEX   = 3'd4,
        PH_AFTER = 3'd5,
        PH_DONE  = 3'd6
    } qsu_phase_t;

    localparam int unsigned CHAR_W = 8;
    localparam int unsigned LEN_W  = 12;

    localparam logic [LEN_W-1:0] CAP_RESET = 12'd1024;

    // character codes
    localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
    localparam logic [CHAR_W-1:0] CH_HT     = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_QUOTE  = 8'h22;
    localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_SEVEN  = 8'h37;
    localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UP_A   = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_F   = 8'h46;
    localparam logic [CHAR_W-1:0] CH_LO_A   = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LO_B   = 8'h62;
    localparam logic [CHAR_W-1:0] CH_LO_F   = 8'h66;
    localparam logic [CHAR_W-1:0] CH_LO_N   = 8'h6E;
    localparam logic [CHAR_W-1:0] CH_LO_T   = 8'h74;
    localparam logic [CHAR_W-1:0] CH_LO_X   = 8'h78;

    // decoded escape bytes
    localparam logic [CHAR_W-1:0] BYTE_BS = 8'h08;
    localparam logic [CHAR_W-1:0] BYTE_HT = 8'h09;
    localparam logic [CHAR_W-1:0] BYTE_LF = 8'h0A;

    // input transaction
    typedef struct packed {
        logic [CHAR_W-1:0] char_byte;
        logic              restart;
    } qsu_item_t;

    // result transaction
    typedef struct packed {
        qsu_kind_t         kind;
        logic [CHAR_W-1:0] data_byte;
        logic [LEN_W-1:0]  length;
        logic              last;
    } qsu_result_t;

    // all results caused by one input transaction
    typedef struct packed {
        logic        two;
        qsu_result_t first;
        qsu_result_t second;
    } qsu_group_t;

endpackage

@@ hdl/qsu_parser.sv @@
// Front end of the unescaper: accepts characters, classifies them and updates the parse state.
// Produces at most one group, of up to two results, per accepted character.
// Depends on qsu_pkg.
module qsu_parser (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [qsu_pkg::LEN_W-1:0] cfg_wdata,
    input  logic                     accept,
    input  qsu_pkg::qsu_item_t       item,
    output logic                     grp_valid,
    output qsu_pkg::qsu_group_t      grp
);
    import qsu_pkg::*;

    qsu_phase_t        phase_reg, phase_next;
    logic [CHAR_W-1:0] acc_reg, acc_next;
    logic [1:0]        dcnt_reg, dcnt_next;
    logic [LEN_W-1:0]  ocnt_reg, ocnt_next;
    logic [LEN_W-1:0]  cap_reg;

    // effective state after an optional restart
    qsu_phase_t        ph_eff;
    logic [CHAR_W-1:0] acc_eff;
    logic [1:0]        dcnt_eff;
    logic [LEN_W-1:0]  ocnt_eff;

    // character classes
    logic [CHAR_W-1:0] c;
    logic              is_ws, is_quote, is_bslash, is_nul, is_oct, is_dec, is_lo_hex, is_up_hex;
    logic              is_hex;
    logic [3:0]        hex_val;

    // escape digit folding
    logic              digit_ok;
    logic [CHAR_W-1:0] acc_fold;
    logic [1:0]        dcnt_fold;
    logic              esc_end;
    logic              flush;
    logic [LEN_W-1:0]  ocnt_base;
    logic              str_err;

    // main result of this character
    logic              m_v;
    qsu_result_t       m_res;

    // decode: restart, character classes and escape digit handling
    always_comb
    begin
        c         = item.char_byte;
        ph_eff    = item.restart ? PH_SKIP : phase_reg;
        acc_eff   = item.restart ? '0 : acc_reg;
        dcnt_eff  = item.restart ? '0 : dcnt_reg;
        ocnt_eff  = item.restart ? '0 : ocnt_reg;

        is_ws     = (c == CH_SPACE) || ((c >= CH_HT) && (c <= CH_CR));
        is_quote  = (c == CH_QUOTE);
        is_bslash = (c == CH_BSLASH);
        is_nul    = (c == CH_NUL);
        is_oct    = (c >= CH_ZERO) && (c <= CH_SEVEN);
        is_dec    = (c >= CH_ZERO) && (c <= CH_NINE);
        is_lo_hex = (c >= CH_LO_A) && (c <= CH_LO_F);
        is_up_hex = (c >= CH_UP_A) && (c <= CH_UP_F);
        is_hex    = is_dec || is_lo_hex || is_up_hex;
        // letters a..f and A..F sit at 1..6 in their low nibble
        hex_val   = is_dec ? c[3:0] : 4'(c[3:0] + 4'd9);

        digit_ok  = (ph_eff == PH_OCT) ? is_oct : is_hex;
        acc_fold  = (ph_eff == PH_OCT) ? {acc_eff[4:0], c[2:0]} : {acc_eff[3:0], hex_val};
        dcnt_fold = 2'(dcnt_eff + 2'd1);
        esc_end   = (ph_eff == PH_OCT) ? (dcnt_fold == 2'd3) : dcnt_fold[1];

        // a digit escape ended by another character: emit it, then treat char as string char
        flush     = ((ph_eff == PH_OCT) || (ph_eff == PH_HEX)) && !digit_ok;
        ocnt_base = ocnt_eff + LEN_W'(flush);
        str_err   = is_nul || (ocnt_base >= cap_reg);
    end

    // next phase
    always_comb
    begin
        qsu_phase_t str_phase;
        if (str_err)
            str_phase = PH_DONE;
        else if (is_bslash)
            str_phase = PH_ESC;
        else if (is_quote)
            str_phase = PH_AFTER;
        else
            str_phase = PH_STR;

        unique case (ph_eff)
            PH_SKIP:
                phase_next = is_ws ? PH_SKIP : (is_quote ? PH_STR : PH_DONE);
            PH_STR:
                phase_next = str_phase;
            PH_ESC:
            begin
                if (is_nul)
                    phase_next = PH_DONE;
                else if (c == CH_LO_X)
                    phase_next = PH_HEX;
                else if (is_oct)
                    phase_next = PH_OCT;
                else
                    phase_next = PH_STR;
            end
            PH_OCT, PH_HEX:
            begin
                if (digit_ok)
                    phase_next = esc_end ? PH_STR : ph_eff;
                else
                    phase_next = str_phase;
            end
            PH_AFTER:
                phase_next = is_ws ? PH_AFTER : (is_quote ? PH_STR : PH_DONE);
            default:
                phase_next = PH_DONE;
        endcase
    end

    // results and data path state
    always_comb
    begin
        qsu_result_t data_r;
        qsu_result_t err_r;
        qsu_result_t str_r;
        logic        str_v;

        data_r           = '{kind: KIND_DATA, data_byte: c, length: '0, last: 1'b0};
        err_r            = '{kind: KIND_ERR, data_byte: '0, length: '0, last: 1'b0};
        str_v            = str_err || !(is_bslash || is_quote);
        str_r            = str_err ? err_r : data_r;

        m_v       = 1'b0;
        m_res     = err_r;
        acc_next  = acc_eff;
        dcnt_next = dcnt_eff;

        unique case (ph_eff)
            PH_SKIP:
                m_v = !is_ws && !is_quote;
            PH_STR:
            begin
                m_v   = str_v;
                m_res = str_r;
            end
            PH_ESC:
            begin
                m_v   = 1'b1;
                m_res = data_r;
                if (is_nul)
                    m_res = err_r;
                else if (c == CH_LO_B)
                    m_res.data_byte = BYTE_BS;
                else if (c == CH_LO_T)
                    m_res.data_byte = BYTE_HT;
                else if (c == CH_LO_N)
                    m_res.data_byte = BYTE_LF;
                else if (c == CH_LO_X)
                begin
                    m_v       = 1'b0;
                    acc_next  = '0;
                    dcnt_next = '0;
                end
                else if (is_oct)
                begin
                    m_v       = 1'b0;
                    acc_next  = {5'd0, c[2:0]};
                    dcnt_next = 2'd1;
                end
            end
            PH_OCT, PH_HEX:
            begin
                if (digit_ok)
                begin
                    acc_next        = acc_fold;
                    dcnt_next       = dcnt_fold;
                    m_v             = esc_end;
                    m_res           = data_r;
                    m_res.data_byte = acc_fold;
                end
                else
                begin
                    m_v   = str_v;
                    m_res = str_r;
                end
            end
            PH_AFTER:
            begin
                m_v = !is_ws;
                if (is_quote)
                begin
                    m_res           = data_r;
                    m_res.data_byte = '0;
                end
                else
                    m_res = '{kind: KIND_DONE, data_byte: '0, length: ocnt_eff, last: 1'b0};
            end
            default:
                m_v = 1'b0;
        endcase

        ocnt_next = ocnt_base + LEN_W'(m_v && (m_res.kind == KIND_DATA));

        // compose the group; the flushed escape byte goes first
        grp = '0;
        if (flush)
        begin
            grp.first  = '{kind: KIND_DATA, data_byte: acc_eff, length: '0, last: !m_v};
            grp.second = m_res;
            grp.second.last = 1'b1;
            grp.two    = m_v;
        end
        else
        begin
            grp.first      = m_res;
            grp.first.last = 1'b1;
        end
        grp_valid = accept && (flush || m_v);
    end

    // parse state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SKIP;
            acc_reg   <= '0;
            dcnt_reg  <= '0;
            ocnt_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            dcnt_reg  <= dcnt_next;
            ocnt_reg  <= ocnt_next;
        end
    end

    // capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cap_reg <= CAP_RESET;
        else if (cfg_we)
            cap_reg <= cfg_wdata;
    end

    // a finished string stays silent until restart
    a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !item.restart && (phase_reg == PH_DONE)) |-> !grp_valid)
        else $error("parser produced a result after completion");

    // an error always ends the string
    a_err_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (grp_valid && (grp.first.kind == KIND_ERR)) |=> (phase_reg == PH_DONE))
        else $error("error result without entering the done phase");

endmodule

@@ hdl/qsu_fifo.sv @@
// Short queue of result groups between the parser and the output stage.
// Register array with a single head read; depth set by a parameter.
// Depends on qsu_pkg.
module qsu_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  qsu_pkg::qsu_group_t wr_data,
    output logic                full,
    input  logic                rd_en,
    output logic                not_empty,
    output qsu_pkg::qsu_group_t rd_data
);
    import qsu_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    qsu_group_t       mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr, do_rd;

    // handshake qualifiers
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_wr     = wr_en && !full;
    assign do_rd     = rd_en && not_empty;
    assign rd_data   = mem[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_data;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_reg + 1'b1);
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_reg + 1'b1);
            if (do_wr && !do_rd)
                count_reg <= CNT_W'(count_reg + 1'b1);
            else if (do_rd && !do_wr)
                count_reg <= CNT_W'(count_reg - 1'b1);
        end
    end

    // upstream never writes into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !full)
        else $error("group written into a full queue");

endmodule

@@ hdl/qsu_emitter.sv @@
// Back end of the unescaper: takes result groups from the queue and hands out one result
// per transaction from an output register. Depends on qsu_pkg.
module qsu_emitter (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                grp_avail,
    input  qsu_pkg::qsu_group_t grp_in,
    output logic                grp_take,
    output logic                empty,
    input  logic                pop,
    output qsu_pkg::qsu_result_t result
);
    import qsu_pkg::*;

    qsu_group_t hold_reg;
    logic       hold_valid_reg, hold_valid_next;
    logic       sel_reg, sel_next;
    logic       pop_ok, group_done;

    // output side and refill decision
    always_comb
    begin
        pop_ok          = pop && hold_valid_reg;
        group_done      = pop_ok && (!hold_reg.two || sel_reg);
        grp_take        = grp_avail && (!hold_valid_reg || group_done);
        hold_valid_next = grp_take || (hold_valid_reg && !group_done);
        if (grp_take)
            sel_next = 1'b0;
        else if (pop_ok)
            sel_next = 1'b1;
        else
            sel_next = sel_reg;
        empty  = !hold_valid_reg;
        result = sel_reg ? hold_reg.second : hold_reg.first;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            sel_reg        <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            sel_reg        <= sel_next;
        end
    end

    // payload register
    always_ff @(posedge clk)
    begin
        if (grp_take)
            hold_reg <= grp_in;
    end

    // second slot is only shown for two-result groups
    a_sel_two: assert property (@(posedge clk) disable iff (!rst_n)
        (hold_valid_reg && sel_reg) |-> hold_reg.two)
        else $error("second result selected in a single-result group");

endmodule

@@ hdl/quoted_string_unescaper.sv @@
// Quoted string unescaper: decodes a C-like quoted string one character per transaction.
//
// Input channel: item (char_byte, restart) is taken when push is high and full is low.
// A character byte of zero marks end of line; restart clears the parse state first.
// Result channel: while empty is low, result holds the oldest pending result
// (data byte, completion with length, or error); pop with empty low takes it.
// Each input transaction causes zero, one or two results; last marks the final one.
// Configuration: cfg_we writes cfg_wdata into the capacity register (bytes, reset 1024).
//
// Throughput: one character per cycle while full is low; the parser updates its state
// in the accept cycle. Results drain at one per cycle from the output register while pop
// is high and empty is low, so a character that causes two results takes two pops; the
// group queue of FIFO_DEPTH entries absorbs this. A taken character's group is written
// into the queue, then into the output register, which shows its results on the ports.
// Reset: parser returns to skipping leading whitespace, the queue and output register empty.
// Receiver stall: results wait in the output register and queue; full rises once the
// queue holds FIFO_DEPTH groups, and characters producing no result still need a free slot.
// Depends on qsu_pkg, qsu_parser, qsu_fifo and qsu_emitter.
module quoted_string_unescaper #(
    parameter int unsigned FIFO_DEPTH = 4
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [qsu_pkg::LEN_W-1:0] cfg_wdata,
    input  logic                      push,
    output logic                      full,
    input  qsu_pkg::qsu_item_t        item,
    output logic                      empty,
    input  logic                      pop,
    output qsu_pkg::qsu_result_t      result
);
    import qsu_pkg::*;

    logic       accept;
    logic       grp_valid;
    qsu_group_t grp;
    logic       q_full, q_not_empty, q_take;
    qsu_group_t q_head;

    // input transaction accepted
    assign accept = push && !q_full;
    assign full   = q_full;

    // front end
    qsu_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .item      (item),
        .grp_valid (grp_valid),
        .grp       (grp)
    );

    // decoupling queue
    qsu_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (grp_valid),
        .wr_data   (grp),
        .full      (q_full),
        .rd_en     (q_take),
        .not_empty (q_not_empty),
        .rd_data   (q_head)
    );

    // back end
    qsu_emitter u_emitter (
        .clk       (clk),
        .rst_n     (rst_n),
        .grp_avail (q_not_empty),
        .grp_in    (q_head),
        .grp_take  (q_take),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

@@ dv/qsu_checker.sv @@
// Scoreboard for the quoted string unescaper: watches both channels and the capacity port.
// Predicts every result from the accepted characters and compares each popped result.
// Depends on qsu_pkg for the transaction structs, kinds, phases and character codes.
`timescale 1ns / 1ps

module qsu_checker
    import qsu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [LEN_W-1:0]  cfg_wdata,
    input  logic              push,
    input  logic              full,
    input  qsu_item_t         item,
    input  logic              empty,
    input  logic              pop,
    input  qsu_result_t       result,
    output int                mismatches,
    output int                pending,
    output int                checked
);

    // decoder state mirrored from the block
    qsu_phase_t         phase;
    logic [CHAR_W-1:0]  accum;
    logic [1:0]         digits;
    logic [LEN_W-1:0]   byte_count;
    logic [LEN_W-1:0]   capacity;

    // decoded results not yet popped, oldest first
    qsu_result_t        decoded_q[$];

    // results caused by the character being decoded
    qsu_result_t        staged[2];
    int                 staged_n;

    function automatic bit is_space(input logic [CHAR_W-1:0] c);
        return c == CH_SPACE || (c >= CH_HT && c <= CH_CR);
    endfunction

    function automatic int hex_value(input logic [CHAR_W-1:0] c);
        if (c >= CH_ZERO && c <= CH_NINE)
            return int'(c - CH_ZERO);
        if (c >= CH_LO_A && c <= CH_LO_F)
            return int'(c - CH_LO_A) + 10;
        if (c >= CH_UP_A && c <= CH_UP_F)
            return int'(c - CH_UP_A) + 10;
        return -1;
    endfunction

    task automatic stage(input qsu_kind_t k, input logic [CHAR_W-1:0] d,
                         input logic [LEN_W-1:0] len);
        if (staged_n < 2)
        begin
            staged[staged_n] = {k, d, len, 1'b0};
            staged_n++;
        end
    endtask

    task automatic emit_byte(input logic [CHAR_W-1:0] b);
        stage(KIND_DATA, b, '0);
        byte_count = byte_count + 1'b1;
    endtask

    task automatic raise_error();
        stage(KIND_ERR, '0, '0);
        phase = PH_DONE;
    endtask

    // ordinary character inside the quotes, capacity checked first
    task automatic string_char(input logic [CHAR_W-1:0] c);
        if (c == CH_NUL || byte_count >= capacity)
            raise_error();
        else if (c == CH_BSLASH)
            phase = PH_ESC;
        else if (c == CH_QUOTE)
            phase = PH_AFTER;
        else
            emit_byte(c);
    endtask

    // advance the decoder by one character and queue what it yields
    task automatic decode_char(input qsu_item_t it);
        logic [CHAR_W-1:0] c;
        int                h;
        c = it.char_byte;
        staged_n = 0;
        if (it.restart)
        begin
            phase = PH_SKIP;
            accum = '0;
            digits = '0;
            byte_count = '0;
        end
        case (phase)
            PH_SKIP:
            begin
                if (!is_space(c))
                begin
                    if (c == CH_QUOTE)
                        phase = PH_STR;
                    else
                        raise_error();
                end
            end
            PH_STR:
                string_char(c);
            PH_ESC:
            begin
                if (c == CH_NUL)
                    raise_error();
                else
                begin
                    phase = PH_STR;
                    if (c == CH_LO_B)
                        emit_byte(BYTE_BS);
                    else if (c == CH_LO_T)
                        emit_byte(BYTE_HT);
                    else if (c == CH_LO_N)
                        emit_byte(BYTE_LF);
                    else if (c == CH_LO_X)
                    begin
                        accum = '0;
                        digits = '0;
                        phase = PH_HEX;
                    end
                    else if (c >= CH_ZERO && c <= CH_SEVEN)
                    begin
                        accum = c - CH_ZERO;
                        digits = 2'd1;
                        phase = PH_OCT;
                    end
                    else
                        emit_byte(c);
                end
            end
            PH_OCT:
            begin
                if (c >= CH_ZERO && c <= CH_SEVEN)
                begin
                    accum = (accum << 3) + (c - CH_ZERO);
                    digits = digits + 2'd1;
                    if (digits == 2'd3)
                    begin
                        emit_byte(accum);
                        phase = PH_STR;
                    end
                end
                else
                begin
                    // escape ended early, the character is then ordinary
                    emit_byte(accum);
                    phase = PH_STR;
                    string_char(c);
                end
            end
            PH_HEX:
            begin
                h = hex_value(c);
                if (h >= 0)
                begin
                    accum = (accum << 4) + CHAR_W'(h);
                    digits = digits + 2'd1;
                    if (digits >= 2'd2)
                    begin
                        emit_byte(accum);
                        phase = PH_STR;
                    end
                end
                else
                begin
                    emit_byte(accum);
                    phase = PH_STR;
                    string_char(c);
                end
            end
            PH_AFTER:
            begin
                if (!is_space(c))
                begin
                    if (c == CH_QUOTE)
                    begin
                        // joined strings get a zero byte between them
                        emit_byte(CH_NUL);
                        phase = PH_STR;
                    end
                    else
                    begin
                        stage(KIND_DONE, '0, byte_count);
                        phase = PH_DONE;
                    end
                end
            end
            default:
            begin
            end
        endcase
        if (staged_n > 0)
            staged[staged_n - 1].last = 1'b1;
        for (int i = 0; i < staged_n; i++)
            decoded_q.push_back(staged[i]);
    endtask

    // compare one popped result with the oldest prediction
    task automatic check_result(input qsu_result_t got);
        qsu_result_t want;
        checked++;
        if (decoded_q.size() == 0)
        begin
            mismatches++;
            $display("%0t: unexpected result kind %0d data %02h length %0d last %0b",
                     $time, got.kind, got.data_byte, got.length, got.last);
        end
        else
        begin
            want = decoded_q.pop_front();
            if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
                got.length !== want.length || got.last !== want.last)
            begin
                mismatches++;
                $display("%0t: expected kind %0d data %02h length %0d last %0b", $time,
                         want.kind, want.data_byte, want.length, want.last);
                $display("%0t:   actual kind %0d data %02h length %0d last %0b", $time,
                         got.kind, got.data_byte, got.length, got.last);
            end
        end
    endtask

    // sample both channels and the capacity port at each rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase = PH_SKIP;
            accum = '0;
            digits = '0;
            byte_count = '0;
            capacity = CAP_RESET;
            decoded_q.delete();
            mismatches = 0;
            pending = 0;
            checked = 0;
        end
        else
        begin
            if (!empty && pop)
                check_result(result);
            if (push && !full)
                decode_char(item);
            if (cfg_we)
                capacity = cfg_wdata;
            pending = decoded_q.size();
        end
    end

endmodule

@@ dv/quoted_string_unescaper_test.sv @@
// Top of the quoted string unescaper testbench: clock, reset, character and pop stimulus.
// Drives directed and random quoted strings over several capacity values; verdict from qsu_checker.
// Depends on qsu_pkg, qsu_checker and the quoted_string_unescaper RTL.
`timescale 1ns / 1ps

module quoted_string_unescaper_test;
    import qsu_pkg::*;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int HOLD_CYCLES   = 80;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_CHARS  = 550;
    localparam int CAP_STEPS     = 5;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [LEN_W-1:0]   cfg_wdata = '0;
    logic               push = 1'b0;
    logic               full;
    qsu_item_t          item = '0;
    logic               empty;
    logic               pop = 1'b0;
    qsu_result_t        result;

    int                 mismatches;
    int                 pending;
    int                 checked;
    int                 cycles = 0;
    int                 chars_sent = 0;
    int                 cap_writes = 0;
    bit                 no_idle = 1'b0;
    bit                 hold_request = 1'b0;
    logic [LEN_W-1:0]   cap_values [CAP_STEPS];

    quoted_string_unescaper dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

    qsu_checker scoreboard (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .push       (push),
        .full       (full),
        .item       (item),
        .empty      (empty),
        .pop        (pop),
        .result     (result),
        .mismatches (mismatches),
        .pending    (pending),
        .checked    (checked)
    );

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("run stopped at the cycle limit with %0d results pending", pending);
            $display("Mismatches found");
            $finish;
        end
    end

    // result side: random stalls, one long hold-off on request
    initial
    begin
        int stall;
        wait (rst_n);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 4);
            if (hold_request)
            begin
                stall = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (stall > 0)
            begin
                @(negedge clk);
                pop <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            pop <= 1'b1;
            do @(posedge clk); while (empty);
        end
    end

    function automatic logic [CHAR_W-1:0] rand_space();
        int v;
        v = $urandom_range(0, 5);
        return (v == 5) ? CH_SPACE : CH_HT + CHAR_W'(v);
    endfunction

    // any byte that is not whitespace or a quote, zero included
    function automatic logic [CHAR_W-1:0] rand_stray();
        logic [CHAR_W-1:0] c;
        do c = CHAR_W'($urandom_range(0, 255));
        while (c == CH_SPACE || (c >= CH_HT && c <= CH_CR) || c == CH_QUOTE);
        return c;
    endfunction

    // ordinary string content: anything but zero, quote and backslash
    function automatic logic [CHAR_W-1:0] rand_plain();
        logic [CHAR_W-1:0] c;
        do c = CHAR_W'($urandom_range(1, 255));
        while (c == CH_QUOTE || c == CH_BSLASH);
        return c;
    endfunction

    function automatic logic [CHAR_W-1:0] hex_char();
        int v;
        v = $urandom_range(0, 21);
        if (v < 10)
            return CH_ZERO + CHAR_W'(v);
        if (v < 16)
            return CH_LO_A + CHAR_W'(v - 10);
        return CH_UP_A + CHAR_W'(v - 16);
    endfunction

    // offer one character after a random gap and wait until it is taken
    task automatic send_char(input logic [CHAR_W-1:0] c, input logic rs);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            @(negedge clk);
            push <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        push <= 1'b1;
        item <= {c, rs};
        do @(posedge clk); while (full);
        chars_sent++;
    endtask

    task automatic send_text(input string s, input logic rs);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], rs && i == 0);
    endtask

    // stop offering and wait until every predicted result has been popped
    task automatic wait_drained();
        @(negedge clk);
        push <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_capacity(input logic [LEN_W-1:0] v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        cap_writes++;
    endtask

    // one piece of string body: plain byte, digit or an escape of some form
    task automatic send_piece();
        int sel;
        int v;
        sel = $urandom_range(0, 19);
        if (sel < 8)
            send_char(rand_plain(), 1'b0);
        else if (sel < 10)
            send_char(hex_char(), 1'b0);
        else
        begin
            send_char(CH_BSLASH, 1'b0);
            case (sel)
                10, 11:
                begin
                    v = $urandom_range(0, 2);
                    send_char(v == 0 ? CH_LO_B : (v == 1 ? CH_LO_T : CH_LO_N), 1'b0);
                end
                12, 13, 14:
                    repeat ($urandom_range(1, 3))
                        send_char(CH_ZERO + CHAR_W'($urandom_range(0, 7)), 1'b0);
                15, 16:
                begin
                    send_char(CH_LO_X, 1'b0);
                    repeat ($urandom_range(0, 2)) send_char(hex_char(), 1'b0);
                end
                17:
                    send_char(CHAR_W'($urandom_range(1, 255)), 1'b0);
                default:
                    send_char(sel[0] ? CH_BSLASH : CH_QUOTE, 1'b0);
            endcase
        end
    endtask

    // mostly well-formed strings, some broken ones and some raw noise
    task automatic send_random_string();
        int sel;
        bit first;
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 6))
                send_char(CHAR_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            return;
        end
        first = 1'b1;
        repeat ($urandom_range(0, 2))
        begin
            send_char(rand_space(), first);
            first = 1'b0;
        end
        // missing opening quote
        if ($urandom_range(0, 19) == 0)
        begin
            send_char(rand_stray(), first);
            return;
        end
        send_char(CH_QUOTE, first);
        repeat ($urandom_range(0, 8)) send_piece();
        sel = $urandom_range(0, 9);
        if (sel == 0)
            send_char(CH_NUL, 1'b0);
        else if (sel == 1)
        begin
            send_char(CH_BSLASH, 1'b0);
            send_char(CH_NUL, 1'b0);
        end
        else
        begin
            // joined strings
            if (sel == 2)
            begin
                send_char(CH_QUOTE, 1'b0);
                repeat ($urandom_range(0, 2)) send_char(rand_space(), 1'b0);
                send_char(CH_QUOTE, 1'b0);
                repeat ($urandom_range(0, 3)) send_piece();
            end
            send_char(CH_QUOTE, 1'b0);
            repeat ($urandom_range(0, 2)) send_char(rand_space(), 1'b0);
            send_char(sel < 6 ? CH_NUL : rand_stray(), 1'b0);
        end
    endtask

    // main sequence
    initial
    begin
        int start;
        bit held;
        bit paused;
        cap_values = '{12'd4095, 12'd1, 12'd6, 12'd1024, 12'd3};
        held = 1'b0;
        paused = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: missing quote, zero before the string, octal, hex and newline escapes,
        // early ended octal, empty hex, join, high byte, completion, eol after backslash
        send_char("Z", 1'b1);
        send_char(CH_NUL, 1'b1);
        send_text(" \"\\101\\7z\\xFf\\x\" \"\\n", 1'b1);
        send_char(8'hC8, 1'b0);
        send_char(CH_QUOTE, 1'b0);
        send_char(CH_NUL, 1'b0);
        send_char(CH_QUOTE, 1'b1);
        send_char(CH_BSLASH, 1'b0);
        send_char(CH_NUL, 1'b0);
        wait_drained();

        // random strings under each capacity
        for (int k = 0; k < CAP_STEPS; k++)
        begin
            set_capacity(cap_values[k]);
            start = chars_sent;
            while (chars_sent - start < RANDOM_CHARS / CAP_STEPS)
            begin
                if (k == 0 && !held && chars_sent - start > 20)
                begin
                    hold_request = 1'b1;
                    held = 1'b1;
                end
                if (k == 3 && !paused && chars_sent - start > 50)
                begin
                    wait_drained();
                    paused = 1'b1;
                end
                no_idle = (k == 3 || k == 4) && (chars_sent - start) < 40;
                send_random_string();
            end
            no_idle = 1'b0;
            wait_drained();
        end

        $display("%0d characters sent under %0d capacity writes, %0d results checked",
                 chars_sent, cap_writes, checked);
        if (mismatches == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/qsu_pkg.sv
hdl/qsu_parser.sv
hdl/qsu_fifo.sv
hdl/qsu_emitter.sv
hdl/quoted_string_unescaper.sv
dv/qsu_checker.sv
dv/quoted_string_unescaper_test.sv
